[rtl/tri_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tri_pkg
// shared widths, operation codes and the queued command format of the trie
// ----------------------------------------------------------------------------
package tri_pkg;

   localparam int OP_W     = 2;
   localparam int LETTER_W = 5;

   // operation code 3 is folded into prefix search when an item is classified
   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_PREFIX = 2'd2
   } op_type;

   // one classified item as it sits in the queue between front and back
   typedef struct packed {
      op_type              op;
      logic [LETTER_W-1:0] letter;
      logic                last;
      logic                empty;
      logic                bad_letter;
   } cmd_type;

endpackage
`default_nettype wire

[rtl/tri_ifs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tri channel interfaces
// valid/ready channels for letter items and for word results
// ----------------------------------------------------------------------------
interface tri_req_if
   import tri_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [LETTER_W-1:0] letter;
   logic                last_letter;
   logic                empty_word;

   modport source (output valid, output operation, output letter, output last_letter,
                   output empty_word, input ready);
   modport sink   (input valid, input operation, input letter, input last_letter,
                   input empty_word, output ready);
endinterface

interface tri_rsp_if;
   logic valid;
   logic ready;
   logic found;
   logic table_full;

   modport source (output valid, output found, output table_full, input ready);
   modport sink   (input valid, input found, input table_full, output ready);
endinterface
`default_nettype wire

[rtl/tri_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tri_ram
// simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module tri_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/tri_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tri_front
// accepts letter items, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module tri_front
   import tri_pkg::*;
#(
   parameter int ALPHABET = 26
) (
   input  wire logic    clock,
   input  wire logic    reset,
   tri_req_if.sink      req_chan,
   input  wire logic    clear_busy,
   output logic         cmd_valid,
   output cmd_type      cmd,
   input  wire logic    cmd_pop
);

   localparam int ALPHA_W = $clog2(ALPHABET + 1);
   localparam int CMP_W   = (ALPHA_W > LETTER_W) ? ALPHA_W : LETTER_W;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   cmd_type    incoming;

   // classify
   always_comb begin
      incoming.letter     = req_chan.letter;
      incoming.last       = req_chan.last_letter | req_chan.empty_word;
      incoming.empty      = req_chan.empty_word;
      incoming.bad_letter = CMP_W'(req_chan.letter) >= CMP_W'(ALPHABET);
      case (req_chan.operation)
         OP_INSERT: incoming.op = OP_INSERT;
         OP_SEARCH: incoming.op = OP_SEARCH;
         default:   incoming.op = OP_PREFIX;
      endcase
   end

   assign req_chan.ready = (count_ff != 2'd2) && !clear_busy;
   assign push           = req_chan.valid && req_chan.ready;
   assign cmd_valid      = count_ff != 2'd0;
   assign cmd            = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !cmd_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule
`default_nettype wire

[rtl/tri_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tri_back
// walks the trie one letter at a time, allocates nodes and forms results
// ----------------------------------------------------------------------------
module tri_back
   import tri_pkg::*;
#(
   parameter int NODES    = 1024,
   parameter int ALPHABET = 26
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd,
   output logic         cmd_pop,
   output logic         clear_busy,
   tri_rsp_if.source    rsp_chan
);

   localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int FREE_W = NODE_W + 1;
   localparam int SLOTS  = NODES * ALPHABET;
   localparam int SLOT_W = $clog2(SLOTS);

   typedef enum logic [5:0] {
      S_CLEAR   = 6'b000001,
      S_IDLE    = 6'b000010,
      S_RESOLVE = 6'b000100,
      S_FINAL   = 6'b001000,
      S_MARK    = 6'b010000,
      S_DONE    = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  clr_ff, clr_in;
   logic [NODE_W-1:0]  cur_ff, cur_in;
   logic [FREE_W-1:0]  free_ff, free_in;
   logic               missed_ff, missed_in;
   logic               exh_ff, exh_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               res_found_ff, res_found_in;
   logic               res_full_ff, res_full_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic               rsp_full_ff, rsp_full_in;

   logic [SLOT_W-1:0]  slot_calc;
   logic               ct_we;
   logic [SLOT_W-1:0]  ct_waddr;
   logic [NODE_W-1:0]  ct_wdata;
   logic [NODE_W-1:0]  ct_rdata;
   logic               mk_we;
   logic [NODE_W-1:0]  mk_waddr;
   logic               mk_wdata;
   logic               mk_rdata;

   // child slot of the current node for the letter at the queue head
   assign slot_calc = SLOT_W'(cur_ff) * SLOT_W'(ALPHABET) + SLOT_W'(cmd.letter);

   tri_ram #(.WIDTH(NODE_W), .DEPTH(SLOTS)) u_child_ram (
      .clock   (clock),
      .wr_en   (ct_we),
      .wr_addr (ct_waddr),
      .wr_data (ct_wdata),
      .rd_addr (slot_calc),
      .rd_data (ct_rdata)
   );

   tri_ram #(.WIDTH(1), .DEPTH(NODES)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mk_we),
      .wr_addr (mk_waddr),
      .wr_data (mk_wdata),
      .rd_addr (cur_ff),
      .rd_data (mk_rdata)
   );

   assign clear_busy          = state_ff == S_CLEAR;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.found      = rsp_found_ff;
   assign rsp_chan.table_full = rsp_full_ff;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      free_in      = free_ff;
      missed_in    = missed_ff;
      exh_in       = exh_ff;
      slot_in      = slot_ff;
      res_found_in = res_found_ff;
      res_full_in  = res_full_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_full_in  = rsp_full_ff;
      cmd_pop      = 1'b0;
      ct_we        = 1'b0;
      ct_waddr     = slot_ff;
      ct_wdata     = free_ff[NODE_W-1:0];
      mk_we        = 1'b0;
      mk_waddr     = cur_ff;
      mk_wdata     = 1'b1;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            ct_we    = 1'b1;
            ct_waddr = clr_ff;
            ct_wdata = '0;
            mk_we    = clr_ff < SLOT_W'(NODES);
            mk_waddr = clr_ff[NODE_W-1:0];
            mk_wdata = 1'b0;
            if (clr_ff == SLOT_W'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (cmd_valid) begin
               if (cmd.empty) begin
                  res_found_in = cmd.op != OP_INSERT;
                  res_full_in  = 1'b0;
                  state_in     = S_DONE;
               end else if (missed_ff || cmd.bad_letter) begin
                  missed_in = 1'b1;
                  if (cmd.last) begin
                     state_in = S_FINAL;
                  end else begin
                     cmd_pop = 1'b1;
                  end
               end else begin
                  slot_in  = slot_calc;
                  state_in = S_RESOLVE;
               end
            end
         end
         S_RESOLVE: begin
            if (ct_rdata != '0) begin
               cur_in = ct_rdata;
            end else if (cmd.op == OP_INSERT && free_ff < FREE_W'(NODES)) begin
               ct_we   = 1'b1;
               cur_in  = free_ff[NODE_W-1:0];
               free_in = free_ff + 1'b1;
            end else begin
               missed_in = 1'b1;
               exh_in    = exh_ff | (cmd.op == OP_INSERT);
            end
            if (cmd.last) begin
               state_in = S_FINAL;
            end else begin
               cmd_pop  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FINAL: begin
            res_full_in = 1'b0;
            case (cmd.op)
               OP_INSERT: begin
                  mk_we        = !missed_ff;
                  res_found_in = 1'b0;
                  res_full_in  = exh_ff;
                  state_in     = S_DONE;
               end
               OP_SEARCH: begin
                  res_found_in = 1'b0;
                  state_in     = missed_ff ? S_DONE : S_MARK;
               end
               default: begin
                  res_found_in = !missed_ff;
                  state_in     = S_DONE;
               end
            endcase
         end
         S_MARK: begin
            res_found_in = mk_rdata;
            res_full_in  = 1'b0;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_full_in  = res_full_ff;
               cmd_pop      = 1'b1;
               cur_in       = '0;
               missed_in    = 1'b0;
               exh_in       = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         cur_ff       <= '0;
         free_ff      <= FREE_W'(1);
         missed_ff    <= 1'b0;
         exh_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cur_ff       <= cur_in;
         free_ff      <= free_in;
         missed_ff    <= missed_in;
         exh_ff       <= exh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      res_found_ff <= res_found_in;
      res_full_ff  <= res_full_in;
      rsp_found_ff <= rsp_found_in;
      rsp_full_ff  <= rsp_full_in;
   end

endmodule
`default_nettype wire

[rtl/trie_insert_lookup.sv]
// the walker reads each letter's child slot in idle and follows or allocates it in resolve;
// after a miss, later letters retire from idle; a word's last item then passes final, plus
// mark for an exact search that has not missed, then done; an empty word goes idle to done
// the two-entry queue hides the front from the walker, which takes one letter at a time, and
// a stalled result channel holds it in done; reset is synchronous, and a clearing pass over
// all NODES*ALPHABET slots zeroes the child table and word marks; no item is accepted till then
`default_nettype none
// ----------------------------------------------------------------------------
// trie_insert_lookup
// prefix tree over a fixed node pool: insert, exact search and prefix search
// ----------------------------------------------------------------------------
module trie_insert_lookup
   import tri_pkg::*;
#(
   parameter int NODES    = 1024,
   parameter int ALPHABET = 26
) (
   input  wire logic clock,
   input  wire logic reset,
   tri_req_if.sink   req_chan,
   tri_rsp_if.source rsp_chan
);

   // classified items waiting for the walker
   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;
   // high during the post-reset clearing pass
   logic    clear_busy;

   // front: takes items, folds op code 3 into prefix, flags letters past the alphabet
   tri_front #(.ALPHABET(ALPHABET)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .clear_busy (clear_busy),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   // back: walks the child table, hands out pool nodes, marks word ends,
   // and parks each word's result in the output register
   tri_back #(.NODES(NODES), .ALPHABET(ALPHABET)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .clear_busy (clear_busy),
      .rsp_chan   (rsp_chan)
   );

`ifndef NO_ASSERTIONS
   // the walker only retires an item that is actually queued
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("walker popped an empty queue");

   // no item gets in while the tables are being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_chan.ready)
      else $error("item accepted during clearing pass");

   // leaving reset always starts the clearing pass
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> clear_busy)
      else $error("clearing pass not started after reset");

   // no result can exist when the clearing pass ends
   a_no_rsp_after_clear: assert property (@(posedge clock) disable iff (reset)
      $fell(clear_busy) |-> !rsp_chan.valid)
      else $error("result present at end of clearing pass");
`endif

endmodule
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for trie_insert_lookup: drives letter items with bursty
// pacing, stalls the result channel, and checks each word result against a
// shadow trie kept inside a small scoreboard class
// ----------------------------------------------------------------------------
module tb_top;
   import tri_pkg::*;

   // block configuration, matches the dut defaults
   localparam int NODES    = 1024;
   localparam int ALPHABET = 26;
   localparam int NODE_W   = 10;

   // spare operation code, the block treats it as a prefix search
   localparam logic [OP_W-1:0]     OP_SPARE   = 2'd3;
   localparam logic [LETTER_W-1:0] LETTER_TOP = '1;
   localparam byte                 CHAR_A     = "a";

   localparam int BANK_SIZE    = 64;   // remembered inserted words
   localparam int BANK_LEN     = 8;    // longest word kept in the bank
   localparam int MAX_WORD     = 16;
   localparam int RANDOM_ITEMS = 200;
   localparam int TAIL_ITEMS   = 60;
   localparam int FULL_WORDS   = 6;    // words offered once the pool is spent
   localparam int HOLD_CYCLES  = 400;  // long result-side hold-off
   localparam int HOLD_AFTER   = 40;   // results seen before the hold-off
   localparam int DRAIN_CYCLES = 20;
   localparam int SHOW_LIMIT   = 30;   // mismatch lines printed at most

   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic [LETTER_W-1:0] letter;
      logic                last_letter;
      logic                empty_word;
   } letter_item_type;

   typedef struct packed {
      logic found;
      logic table_full;
   } word_result_type;

   // result-side stall patterns
   typedef enum int {
      ALWAYS_READY,
      COIN_FLIP,
      EVERY_THIRD,
      MOSTLY_STALLED
   } stall_mode_type;

   // ------------------------------------------------------------------------
   // scoreboard: shadow copy of the trie plus the queue of awaited answers
   // ------------------------------------------------------------------------
   class trie_shadow;
      logic [NODE_W-1:0] child_of [NODES*ALPHABET];
      bit                word_ends [NODES];
      int unsigned       free_node;
      int unsigned       walk_node;
      bit                walk_missed;
      bit                walk_full;
      word_result_type   awaited_answers[$];
      int unsigned       results_seen;
      int unsigned       mismatches;

      function new();
         foreach (child_of[i]) child_of[i] = '0;
         foreach (word_ends[i]) word_ends[i] = 1'b0;
         free_node    = 1;
         results_seen = 0;
         mismatches   = 0;
         end_walk();
      endfunction

      // every result sends the walk back to the root
      function void end_walk();
         walk_node   = 0;
         walk_missed = 1'b0;
         walk_full   = 1'b0;
      endfunction

      function void step_walk(logic [OP_W-1:0] op, logic [LETTER_W-1:0] letter);
         int unsigned slot;
         int unsigned child;
         if (walk_missed) return;
         // out-of-alphabet letter: the path misses, no pool flag
         if (letter >= ALPHABET) begin
            walk_missed = 1'b1;
            return;
         end
         slot  = walk_node * ALPHABET + letter;
         child = child_of[slot];
         if (child == 0) begin
            if (op != OP_INSERT) begin
               walk_missed = 1'b1;
               return;
            end
            // pool spent: stop walking, flag it, earlier allocations stay
            if (free_node >= NODES) begin
               walk_full   = 1'b1;
               walk_missed = 1'b1;
               return;
            end
            child = free_node;
            free_node++;
            child_of[slot] = NODE_W'(child);
         end
         walk_node = child;
      endfunction

      // called for each accepted item
      function void note_item(letter_item_type item);
         word_result_type answer;
         answer = '0;
         // empty word ends the word whatever the last bit says
         if (item.empty_word) begin
            answer.found = (item.operation != OP_INSERT);
            end_walk();
            awaited_answers.push_back(answer);
            return;
         end
         step_walk(item.operation, item.letter);
         if (!item.last_letter) return;
         // the final item's own operation decides the result
         if (item.operation == OP_INSERT) begin
            if (!walk_missed) word_ends[walk_node] = 1'b1;
            answer.table_full = walk_full;
         end else if (item.operation == OP_SEARCH) begin
            answer.found = !walk_missed && word_ends[walk_node];
         end else begin
            answer.found = !walk_missed;
         end
         end_walk();
         awaited_answers.push_back(answer);
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= SHOW_LIMIT) $display("%0t mismatch: %s", $time, what);
      endtask

      // called for each accepted result
      task check_result(logic found, logic table_full);
         word_result_type want;
         results_seen++;
         if (awaited_answers.size() == 0) begin
            report_mismatch($sformatf("result with no word pending (found %b, table_full %b)",
                                      found, table_full));
            return;
         end
         want = awaited_answers.pop_front();
         if (found !== want.found)
            report_mismatch($sformatf("result %0d found %b, expected %b",
                                      results_seen, found, want.found));
         if (table_full !== want.table_full)
            report_mismatch($sformatf("result %0d table_full %b, expected %b",
                                      results_seen, table_full, want.table_full));
      endtask
   endclass

   // ------------------------------------------------------------------------
   // clock, reset, channels and the block
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #10 clock = ~clock;

   tri_req_if req_chan ();
   tri_rsp_if rsp_chan ();

   trie_insert_lookup dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   trie_shadow shadow = new();

   // sender state
   int unsigned         burst_left     = 0;
   int unsigned         items_accepted = 0;
   logic [LETTER_W-1:0] word_buf [MAX_WORD];
   logic [OP_W-1:0]     op_buf [MAX_WORD];

   // inserted words kept so lookups can hit stored paths
   logic [LETTER_W-1:0] bank_letters [BANK_SIZE][BANK_LEN];
   int unsigned         bank_len [BANK_SIZE];
   int unsigned         bank_count = 0;

   // drop valid, with junk on the payload, for as many cycles as asked
   task automatic idle_sender(int unsigned cycles);
      if (cycles == 0) return;
      req_chan.valid       <= 1'b0;
      req_chan.operation   <= OP_W'($urandom);
      req_chan.letter      <= LETTER_W'($urandom);
      req_chan.last_letter <= 1'($urandom);
      req_chan.empty_word  <= 1'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   // offer one item and hold it until the block takes it
   task automatic offer_item(letter_item_type item);
      // bursts of random length, gaps between them, some long gap-free runs
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(20, 60);
         end else begin
            idle_sender($urandom_range(1, 6));
            burst_left = $urandom_range(1, 12);
         end
      end
      burst_left--;
      req_chan.valid       <= 1'b1;
      req_chan.operation   <= item.operation;
      req_chan.letter      <= item.letter;
      req_chan.last_letter <= item.last_letter;
      req_chan.empty_word  <= item.empty_word;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_accepted++;
      shadow.note_item(item);
   endtask

   // send word_buf/op_buf as one word, last bit on the final letter
   task automatic send_word(int unsigned len);
      letter_item_type item;
      for (int i = 0; i < len; i++) begin
         item.operation   = op_buf[i];
         item.letter      = word_buf[i];
         item.last_letter = (i == len - 1);
         item.empty_word  = 1'b0;
         offer_item(item);
      end
   endtask

   // a word written as text, one operation for all its letters
   task automatic send_text(logic [OP_W-1:0] op, string text);
      for (int i = 0; i < text.len(); i++) begin
         word_buf[i] = LETTER_W'(text[i] - CHAR_A);
         op_buf[i]   = op;
      end
      send_word(text.len());
   endtask

   task automatic send_empty(logic [OP_W-1:0] op, logic [LETTER_W-1:0] letter, logic last);
      letter_item_type item;
      item.operation   = op;
      item.letter      = letter;
      item.last_letter = last;
      item.empty_word  = 1'b1;
      offer_item(item);
   endtask

   // well-formed words over a narrow alphabet so lookups often hit,
   // with stray letters, mixed operations and empty words as noise
   task automatic send_random_word();
      int unsigned         pick;
      int unsigned         len;
      int unsigned         slot;
      int unsigned         stored;
      logic [OP_W-1:0]     op;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         send_empty(OP_W'($urandom), LETTER_W'($urandom), 1'($urandom));
         return;
      end
      pick = $urandom_range(0, 19);
      if (pick < 7)       op = OP_INSERT;
      else if (pick < 12) op = OP_SEARCH;
      else if (pick < 18) op = OP_PREFIX;
      else                op = OP_SPARE;
      stored = (bank_count < BANK_SIZE) ? bank_count : BANK_SIZE;
      if (op != OP_INSERT && stored > 0 && $urandom_range(0, 1) == 1) begin
         // replay a stored word, or a prefix of it for prefix queries
         slot = $urandom_range(0, stored - 1);
         len  = bank_len[slot];
         if (op != OP_SEARCH) len = $urandom_range(1, len);
         for (int i = 0; i < len; i++) word_buf[i] = bank_letters[slot][i];
         if ($urandom_range(0, 4) == 0)
            word_buf[$urandom_range(0, len - 1)] = LETTER_W'($urandom_range(0, 3));
      end else begin
         len = $urandom_range(1, 6);
         for (int i = 0; i < len; i++)
            word_buf[i] = ($urandom_range(0, 24) == 0) ? LETTER_W'($urandom)
                                                        : LETTER_W'($urandom_range(0, 3));
      end
      // now and then a letter walks with a different operation
      for (int i = 0; i < len; i++)
         op_buf[i] = ($urandom_range(0, 11) == 0) ? OP_W'($urandom) : op;
      op_buf[len - 1] = op;
      if (op == OP_INSERT && len <= BANK_LEN) begin
         slot = bank_count % BANK_SIZE;
         for (int i = 0; i < len; i++) bank_letters[slot][i] = word_buf[i];
         bank_len[slot] = len;
         bank_count++;
      end
      send_word(len);
   endtask

   // long insert over the full alphabet, almost every letter takes a node
   task automatic send_long_insert();
      int unsigned len;
      len = $urandom_range(10, MAX_WORD);
      for (int i = 0; i < len; i++) begin
         word_buf[i] = LETTER_W'($urandom_range(0, ALPHABET - 1));
         op_buf[i]   = OP_INSERT;
      end
      send_word(len);
   endtask

   // sender pause until every awaited answer is back
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (shadow.awaited_answers.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int unsigned phase_start;
      int unsigned full_words;
      req_chan.valid       <= 1'b0;
      req_chan.operation   <= OP_INSERT;
      req_chan.letter      <= '0;
      req_chan.last_letter <= 1'b0;
      req_chan.empty_word  <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty words, one with the last bit low
      send_empty(OP_SEARCH, LETTER_TOP, 1'b0);
      send_empty(OP_PREFIX, '0, 1'b1);
      send_empty(OP_INSERT, LETTER_W'(ALPHABET - 1), 1'b1);
      // lookup on an empty tree
      send_text(OP_SEARCH, "a");
      // store a word at the alphabet ends, then look it up every way
      send_text(OP_INSERT, "az");
      send_text(OP_SEARCH, "az");
      send_text(OP_SEARCH, "a");
      send_text(OP_PREFIX, "a");
      send_text(OP_SPARE, "az");
      // out-of-alphabet letters on insert and lookup
      word_buf[0] = '0;
      word_buf[1] = LETTER_TOP;
      op_buf[0]   = OP_INSERT;
      op_buf[1]   = OP_INSERT;
      send_word(2);
      word_buf[0] = LETTER_W'(ALPHABET);
      op_buf[0]   = OP_PREFIX;
      send_word(1);
      // insert after a missed lookup does not walk on
      word_buf[0] = LETTER_W'("q" - CHAR_A);
      word_buf[1] = LETTER_W'("r" - CHAR_A);
      op_buf[0]   = OP_SEARCH;
      op_buf[1]   = OP_INSERT;
      send_word(2);
      // lookup that hits, then an insert that extends the path
      word_buf[0] = '0;
      word_buf[1] = LETTER_W'(1);
      op_buf[0]   = OP_SEARCH;
      op_buf[1]   = OP_INSERT;
      send_word(2);
      send_text(OP_SEARCH, "ab");
      // empty word in the middle of a word resets the walk
      op_buf[0]   = OP_INSERT;
      word_buf[0] = LETTER_W'("c" - CHAR_A);
      send_word(0);
      offer_item('{OP_INSERT, LETTER_W'("c" - CHAR_A), 1'b0, 1'b0});
      send_empty(OP_SEARCH, LETTER_W'("c" - CHAR_A), 1'b1);
      send_text(OP_PREFIX, "c");
      wait_drained();

      // random words over a narrow alphabet
      phase_start = items_accepted;
      while (items_accepted - phase_start < RANDOM_ITEMS) send_random_word();
      wait_drained();

      // run the node pool dry, then keep inserting to get table_full
      full_words = 0;
      while (full_words < FULL_WORDS) begin
         if (shadow.free_node >= NODES) full_words++;
         if ($urandom_range(0, 4) == 0) send_random_word();
         else                           send_long_insert();
      end

      // lookups and inserts on a full table
      phase_start = items_accepted;
      while (items_accepted - phase_start < TAIL_ITEMS) send_random_word();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // result side: one long hold-off, then rotating stall patterns
   // ------------------------------------------------------------------------
   initial begin : receiver
      stall_mode_type mode;
      int unsigned    mode_left;
      int unsigned    tick;
      bit             held;
      mode      = ALWAYS_READY;
      mode_left = 0;
      tick      = 0;
      held      = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         // hold off while the sender keeps offering, so the block backs up
         if (!held && shadow.results_seen >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(ALWAYS_READY, MOSTLY_STALLED));
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         tick++;
         case (mode)
            ALWAYS_READY: rsp_chan.ready <= 1'b1;
            COIN_FLIP:    rsp_chan.ready <= 1'($urandom);
            EVERY_THIRD:  rsp_chan.ready <= (tick % 3 == 0);
            default:      rsp_chan.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // every accepted result goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         shadow.check_result(rsp_chan.found, rsp_chan.table_full);
   end

   // watchdog: covers the clearing pass after reset and the slowest run
   // several times over
   initial begin : watchdog
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
